### rtl/core/blp_pkg.sv
// ----------------------------------------------------------------------------
// blp_pkg
// Shared types and constants for the Bresenham line plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package blp_pkg;

	localparam int BLP_SCREEN_WIDTH  = 128;
	localparam int BLP_SCREEN_HEIGHT = 64;

	localparam logic [5:0] VOFF_RESET = 6'd7;

	// command codes (s_tuser)
	localparam logic [1:0] CMD_LINE  = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// write modes: clear all planes, or set planes 0..mode-1
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ONE   = 2'd1;
	localparam logic [1:0] MODE_TWO   = 2'd2;
	localparam logic [1:0] MODE_ALL   = 2'd3;

	// coordinates after offset: -256..318
	typedef logic signed [9:0] coord_t;

	typedef struct packed {
		coord_t     x0;
		coord_t     y0;
		logic [8:0] adx;
		logic [8:0] ady;
		logic       x_neg;
		logic       y_neg;
		logic [1:0] mode;
	} line_cmd_t;

	typedef struct packed {
		logic       vld;
		logic [2:0] xlow;
		logic [1:0] mode;
	} pix_ctl_t;

endpackage

`default_nettype wire

### rtl/core/blp_ram.sv
// ----------------------------------------------------------------------------
// blp_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/blp_stepper.sv
// ----------------------------------------------------------------------------
// blp_stepper
// Bresenham walker: one pixel position per cycle, with screen clipping and
// framebuffer address generation.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_stepper #(
	parameter int SCREEN_WIDTH  = blp_pkg::BLP_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = blp_pkg::BLP_SCREEN_HEIGHT,
	parameter int ADDR_W        = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire blp_pkg::line_cmd_t  cmd,
	output blp_pkg::pix_ctl_t        pix_s1,
	output logic [ADDR_W-1:0]        addr_s1,
	output logic                     busy,
	output logic [9:0]               count
);

	import blp_pkg::*;

	localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;

	coord_t     x_q, y_q;
	logic [8:0] major_q, minor_q, remain_q;
	logic [9:0] acc_q, acc_sum, acc_next;
	logic       x_major_q, x_neg_q, y_neg_q, active_q, over;
	logic [1:0] mode_q;
	logic [9:0] count_q;
	logic       onscr;
	coord_t     x_step, y_step, x_next, y_next;
	logic [8:0] st_major, st_minor;

	assign st_major = (cmd.adx > cmd.ady) ? cmd.adx : cmd.ady;
	assign st_minor = (cmd.adx > cmd.ady) ? cmd.ady : cmd.adx;

	always_comb begin
		onscr = !x_q[9] && !y_q[9]
			&& (32'(x_q[8:0]) < SCREEN_WIDTH) && (32'(y_q[8:0]) < SCREEN_HEIGHT);
		acc_sum  = acc_q + {1'b0, minor_q};
		over     = acc_sum > {1'b0, major_q};
		acc_next = over ? (acc_sum - {1'b0, major_q}) : acc_sum;
		x_step   = x_neg_q ? -10'sd1 : 10'sd1;
		y_step   = y_neg_q ? -10'sd1 : 10'sd1;
		x_next   = x_q;
		y_next   = y_q;
		if (x_major_q) begin
			x_next = x_q + x_step;
			if (over) y_next = y_q + y_step;
		end else begin
			y_next = y_q + y_step;
			if (over) x_next = x_q + x_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pix_s1    <= '0;
			count_q   <= '0;
			x_q       <= '0;
			y_q       <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			remain_q  <= '0;
			acc_q     <= '0;
			x_major_q <= 1'b0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			mode_q    <= MODE_CLEAR;
		end else begin
			pix_s1.vld  <= active_q && onscr;
			pix_s1.xlow <= x_q[2:0];
			pix_s1.mode <= mode_q;
			if (start) begin
				x_q       <= cmd.x0;
				y_q       <= cmd.y0;
				major_q   <= st_major;
				minor_q   <= st_minor;
				acc_q     <= {2'b0, st_major[8:1]};
				remain_q  <= (st_major == 9'd0) ? 9'd1 : st_major;
				x_major_q <= cmd.adx > cmd.ady;
				x_neg_q   <= cmd.x_neg;
				y_neg_q   <= cmd.y_neg;
				mode_q    <= cmd.mode;
				active_q  <= 1'b1;
				count_q   <= '0;
			end else if (active_q) begin
				if (onscr) count_q <= count_q + 10'd1;
				remain_q <= remain_q - 9'd1;
				if (remain_q == 9'd1) active_q <= 1'b0;
				x_q   <= x_next;
				y_q   <= y_next;
				acc_q <= acc_next;
			end
		end
	end

	// byte address of the current position (only meaningful on screen)
	always_ff @(posedge clk) begin
		addr_s1 <= ADDR_W'(32'(y_q[8:0]) * ROW_BYTES + 32'(x_q[8:3]));
	end

	assign busy  = active_q || pix_s1.vld;
	assign count = count_q;

endmodule

`default_nettype wire

### rtl/core/blp_rmw.sv
// ----------------------------------------------------------------------------
// blp_rmw
// Pixel read-modify-write stage: merges the plane mask into the word read
// from the framebuffer, forwarding the previous write on an address match.
// ----------------------------------------------------------------------------
`default_nettype none

module blp_rmw #(
	parameter int ADDR_W = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire blp_pkg::pix_ctl_t  pix_s1,
	input  wire logic [ADDR_W-1:0]  addr_s1,
	input  wire logic [23:0]        rdata,
	output logic                    we,
	output logic [ADDR_W-1:0]       waddr,
	output logic [23:0]             wdata,
	output logic                    busy
);

	import blp_pkg::*;

	pix_ctl_t          pix_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic              last_vld_q;
	logic [ADDR_W-1:0] last_addr_q;
	logic [23:0]       last_data_q;
	logic [23:0]       base;
	logic [7:0]        m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2     <= '0;
			last_vld_q <= 1'b0;
		end else begin
			pix_s2     <= pix_s1;
			last_vld_q <= pix_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		addr_s2     <= addr_s1;
		last_addr_q <= addr_s2;
		last_data_q <= wdata;
	end

	always_comb begin
		// the write from the previous cycle is not yet visible in rdata
		base = (last_vld_q && last_addr_q == addr_s2) ? last_data_q : rdata;
		m    = 8'h80 >> pix_s2.xlow;
		case (pix_s2.mode)
			MODE_CLEAR: wdata = base & ~{m, m, m};
			MODE_ONE:   wdata = base | {8'h00, 8'h00, m};
			MODE_TWO:   wdata = base | {8'h00, m, m};
			MODE_ALL:   wdata = base | {m, m, m};
			default:    wdata = base;
		endcase
	end

	assign we    = pix_s2.vld;
	assign waddr = addr_s2;
	assign busy  = pix_s2.vld;

endmodule

`default_nettype wire

### rtl/core/bresenham_line_plotter_core.sv
// ----------------------------------------------------------------------------
// bresenham_line_plotter_core
// Line, gray pixel, word read and clear commands on a three-plane framebuffer.
// ----------------------------------------------------------------------------
// A line walks N positions (N = max(|dx|,|dy|), at least 1), a line shade
// that draws nothing skips the walk, and a clear rewrites every
// framebuffer word; the core takes one command at a time.
// The walk does one framebuffer read-modify-write per cycle through the
// single RAM read port, with forwarding between neighboring pixels.
// After reset a clearing pass zeroes all ROW_BYTES*SCREEN_HEIGHT words of the
// framebuffer with s_tready low; vertical_offset resets to 7.
`default_nettype none

module bresenham_line_plotter_core #(
	parameter int SCREEN_WIDTH  = blp_pkg::BLP_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = blp_pkg::BLP_SCREEN_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// x_start[8:0] y_start[17:9] x_end[26:18] y_end[35:27] shade[37:36]
	// byte_index[47:38]
	input  wire logic [47:0] s_tdata,
	// command[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[23:0] pixels_plotted[33:24], zero pad [39:34]
	output logic [39:0]      m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import blp_pkg::*;

	localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
	localparam int FB_DEPTH  = ROW_BYTES * SCREEN_HEIGHT;
	localparam int ADDR_W    = $clog2(FB_DEPTH);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_READ   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [5:0]        voff_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clr_cmd_q, rd_ok_q;
	logic [23:0]       pend_data_q, out_data_q;
	logic [9:0]        pend_count_q, out_count_q;
	logic              m_tvalid_q;

	// input fields
	logic [1:0]  command, shade;
	logic [8:0]  x_start, y_start, x_end, y_end;
	logic [9:0]  byte_index;
	coord_t      xs, ys, xe, ye, dx, dy;
	line_cmd_t   cmd;
	logic        accept, start, rd_in_range;

	// datapath links
	pix_ctl_t          pix_s1;
	logic [ADDR_W-1:0] addr_s1, rmw_waddr, ram_waddr, ram_raddr;
	logic              st_busy, rmw_busy, rmw_we, ram_we;
	logic [23:0]       rmw_wdata, ram_wdata, ram_rdata;
	logic [9:0]        st_count;

	assign x_start    = s_tdata[8:0];
	assign y_start    = s_tdata[17:9];
	assign x_end      = s_tdata[26:18];
	assign y_end      = s_tdata[35:27];
	assign shade      = s_tdata[37:36];
	assign byte_index = s_tdata[47:38];
	assign command    = s_tuser;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		xs = {x_start[8], x_start};
		xe = {x_end[8], x_end};
		ys = {y_start[8], y_start};
		ye = {y_end[8], y_end};
		dx = xe - xs;
		dy = ye - ys;   // offset cancels in the difference
		cmd = '0;
		if (command == CMD_LINE) begin
			cmd.x0    = xs;
			cmd.y0    = ys + {4'b0, voff_q};
			cmd.adx   = dx[9] ? 9'(-dx) : dx[8:0];
			cmd.ady   = dy[9] ? 9'(-dy) : dy[8:0];
			cmd.x_neg = dx[9];
			cmd.y_neg = dy[9];
			cmd.mode  = (shade == 2'd0) ? MODE_CLEAR : MODE_ALL;
		end else begin
			cmd.x0   = xs;
			cmd.y0   = ys;
			cmd.mode = shade;
		end
	end

	assign start = accept && ((command == CMD_LINE && shade <= 2'd1) || command == CMD_PIXEL);
	assign rd_in_range = 32'(byte_index) < FB_DEPTH;

	blp_stepper #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.ADDR_W        (ADDR_W)
	) u_stepper (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.pix_s1  (pix_s1),
		.addr_s1 (addr_s1),
		.busy    (st_busy),
		.count   (st_count)
	);

	blp_rmw #(
		.ADDR_W (ADDR_W)
	) u_rmw (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_s1  (pix_s1),
		.addr_s1 (addr_s1),
		.rdata   (ram_rdata),
		.we      (rmw_we),
		.waddr   (rmw_waddr),
		.wdata   (rmw_wdata),
		.busy    (rmw_busy)
	);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = rmw_we;
			ram_waddr = rmw_waddr;
			ram_wdata = rmw_wdata;
		end
		ram_raddr = (state_q == ST_WALK) ? addr_s1 : ADDR_W'(byte_index);
	end

	blp_ram #(
		.WIDTH (24),
		.DEPTH (FB_DEPTH),
		.AW    (ADDR_W)
	) u_fb (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			clr_cmd_q    <= 1'b0;
			rd_ok_q      <= 1'b0;
			m_tvalid_q   <= 1'b0;
			pend_data_q  <= '0;
			pend_count_q <= '0;
			out_data_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_RESULT) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == ADDR_W'(FB_DEPTH - 1)) begin
						clr_cnt_q <= '0;
						clr_cmd_q <= 1'b0;
						if (clr_cmd_q) begin
							pend_data_q  <= '0;
							pend_count_q <= '0;
							state_q      <= ST_RESULT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_LINE, CMD_PIXEL: begin
								if (start) begin
									state_q <= ST_WALK;
								end else begin
									// line shade with no effect
									pend_data_q  <= '0;
									pend_count_q <= '0;
									state_q      <= ST_RESULT;
								end
							end
							CMD_READ: begin
								rd_ok_q <= rd_in_range;
								state_q <= ST_READ;
							end
							CMD_CLEAR: begin
								clr_cmd_q <= 1'b1;
								state_q   <= ST_CLEAR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WALK: begin
					if (!st_busy && !rmw_busy) begin
						pend_data_q  <= '0;
						pend_count_q <= st_count;
						state_q      <= ST_RESULT;
					end
				end
				ST_READ: begin
					pend_data_q  <= rd_ok_q ? ram_rdata : 24'd0;
					pend_count_q <= '0;
					state_q      <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						out_data_q  <= pend_data_q;
						out_count_q <= pend_count_q;
						m_tvalid_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_count_q, out_data_q};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voff_q <= VOFF_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			voff_q <= pwdata[5:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {26'd0, voff_q};

endmodule

`default_nettype wire

### tb/sv/bresenham_line_plotter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_plotter_checker
// Watches the command, result and register channels of the line plotter.
// Keeps a shadow framebuffer and offset register and predicts the result of
// every accepted command. Each result transaction is compared against the
// oldest prediction.
// ----------------------------------------------------------------------------

module bresenham_line_plotter_checker #(
	parameter logic [2:0] VOFF_ADDR = 3'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          pending
);
	import blp_pkg::*;

	localparam int ROW_BYTES = (BLP_SCREEN_WIDTH + 7) / 8;
	localparam int FB_DEPTH  = ROW_BYTES * BLP_SCREEN_HEIGHT;

	typedef struct {
		logic [1:0]  cmd;
		logic [23:0] word;
		logic [9:0]  count;
	} plot_result_t;

	logic [23:0]  fb_shadow [FB_DEPTH];
	logic [5:0]   voff_shadow;
	plot_result_t results_due [$];

	// returns 1 when the position is on screen and was written
	function automatic int plot_at(int x, int y, logic [1:0] mode);
		int          idx;
		int          bitpos;
		logic [23:0] mask;
		if (x < 0 || x >= BLP_SCREEN_WIDTH || y < 0 || y >= BLP_SCREEN_HEIGHT)
			return 0;
		idx    = y * ROW_BYTES + x / 8;
		bitpos = 7 - x % 8;
		if (mode == MODE_CLEAR) begin
			mask = 24'h010101 << bitpos;
			fb_shadow[idx] = fb_shadow[idx] & ~mask;
		end else begin
			mask = 24'h000001 << bitpos;
			if (mode != MODE_ONE)
				mask = mask | (24'h000100 << bitpos);
			if (mode == MODE_ALL)
				mask = mask | (24'h010000 << bitpos);
			fb_shadow[idx] = fb_shadow[idx] | mask;
		end
		return 1;
	endfunction

	function automatic int trace_line(int xa, int ya, int xb, int yb, logic [1:0] shade);
		int         x, y, dx, dy, sx, sy, acc, n;
		logic [1:0] mode;
		if (shade != MODE_CLEAR && shade != MODE_ONE)
			return 0;
		mode = (shade == MODE_CLEAR) ? MODE_CLEAR : MODE_ALL;
		ya = ya + int'(voff_shadow);
		yb = yb + int'(voff_shadow);
		x  = xa;
		y  = ya;
		dx = xb - xa;
		dy = yb - ya;
		sx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
		sy = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		n = plot_at(x, y, mode);
		// endpoint excluded; ties go to the y axis
		if (dx > dy) begin
			acc = dx / 2;
			for (int i = 1; i < dx; i++) begin
				x   = x + sx;
				acc = acc + dy;
				if (acc > dx) begin
					acc = acc - dx;
					y   = y + sy;
				end
				n = n + plot_at(x, y, mode);
			end
		end else begin
			acc = dy / 2;
			for (int i = 1; i < dy; i++) begin
				y   = y + sy;
				acc = acc + dx;
				if (acc > dy) begin
					acc = acc - dy;
					x   = x + sx;
				end
				n = n + plot_at(x, y, mode);
			end
		end
		return n;
	endfunction

	function automatic plot_result_t predict_command(logic [1:0] cmd, logic [47:0] d);
		plot_result_t r;
		int           xs, ys, xe, ye;
		xs      = $signed(d[8:0]);
		ys      = $signed(d[17:9]);
		xe      = $signed(d[26:18]);
		ye      = $signed(d[35:27]);
		r.cmd   = cmd;
		r.word  = '0;
		r.count = '0;
		case (cmd)
			CMD_LINE:  r.count = 10'(trace_line(xs, ys, xe, ye, d[37:36]));
			CMD_PIXEL: r.count = 10'(plot_at(xs, ys, d[37:36]));
			CMD_READ: begin
				if (int'(d[47:38]) < FB_DEPTH)
					r.word = fb_shadow[d[47:38]];
			end
			default: begin
				for (int i = 0; i < FB_DEPTH; i++)
					fb_shadow[i] = '0;
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		if (mismatches < 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		plot_result_t exp_res;
		if (!arst_n) begin
			for (int i = 0; i < FB_DEPTH; i++)
				fb_shadow[i] = '0;
			voff_shadow = VOFF_RESET;
			results_due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == VOFF_ADDR)
				voff_shadow = pwdata[5:0];
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result data %h count %0d",
						m_tdata[23:0], m_tdata[33:24]));
				end else begin
					exp_res = results_due.pop_front();
					if (m_tdata[23:0] !== exp_res.word || m_tdata[33:24] !== exp_res.count)
						flag_mismatch($sformatf(
							"cmd %0d: expected data %h count %0d, got data %h count %0d",
							exp_res.cmd, exp_res.word, exp_res.count,
							m_tdata[23:0], m_tdata[33:24]));
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(predict_command(s_tuser, s_tdata));
			pending <= results_due.size();
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the Bresenham line plotter core: a directed set of commands,
// then random commands in phases with different offsets and idle/stall
// patterns, including one long result-side hold-off. Checking is done by
// the checker instance; this module drives and gives the verdict.
// ----------------------------------------------------------------------------

module tb;
	import blp_pkg::*;

	localparam logic [2:0] VOFF_ADDR       = 3'd0;
	localparam int         RUN_LIMIT       = 8_000_000;
	localparam int         ITEMS_PER_PHASE = 420;
	localparam int         HOLD_CYCLES     = 600;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tready;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;
	wire  [31:0] prdata;
	wire         pready;

	int mismatches;
	int pending;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int holds_served   = 0;
	int cycle_count    = 0;

	bresenham_line_plotter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bresenham_line_plotter_checker #(
		.VOFF_ADDR (VOFF_ADDR)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// mostly near the screen, now and then anywhere in the 9-bit range
	function automatic int pick_coord(int lo, int hi);
		if ($urandom_range(99) < 6)
			return int'($urandom_range(511)) - 256;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	task automatic send_cmd(input logic [1:0] cmd, input int xs, input int ys,
		input int xe, input int ye, input logic [1:0] shade, input logic [9:0] bidx);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {bidx, shade, ye[8:0], xe[8:0], ys[8:0], xs[8:0]};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic send_random();
		int         r;
		logic [1:0] cmd;
		logic [1:0] shade;
		r   = $urandom_range(99);
		cmd = (r < 42) ? CMD_LINE : (r < 72) ? CMD_PIXEL : (r < 98) ? CMD_READ : CMD_CLEAR;
		shade = 2'($urandom_range(3));
		// lines with shade two or three draw nothing; keep them a minority
		if (cmd == CMD_LINE && $urandom_range(99) < 80)
			shade = 2'($urandom_range(1));
		send_cmd(cmd, pick_coord(-8, 135), pick_coord(-70, 71),
			pick_coord(-8, 135), pick_coord(-70, 71), shade, 10'($urandom_range(1023)));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_voffset(input logic [5:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= VOFF_ADDR;
		pwdata  <= {26'($urandom_range(32'h03FF_FFFF)), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [5:0] voff;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_LINE;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed, offset still at its reset value
		send_cmd(CMD_READ, 0, 0, 0, 0, MODE_CLEAR, 10'd0);
		send_cmd(CMD_PIXEL, 0, 0, 0, 0, MODE_ALL, 10'd0);
		send_cmd(CMD_PIXEL, 127, 63, 0, 0, MODE_ONE, 10'd0);
		send_cmd(CMD_PIXEL, 127, 0, 0, 0, MODE_TWO, 10'd0);
		send_cmd(CMD_PIXEL, 8, 1, 0, 0, MODE_ALL, 10'd0);
		send_cmd(CMD_PIXEL, 8, 1, 0, 0, MODE_CLEAR, 10'd0);
		send_cmd(CMD_PIXEL, -1, 0, 0, 0, MODE_ALL, 10'd0);
		send_cmd(CMD_PIXEL, 128, 5, 0, 0, MODE_ALL, 10'd0);
		send_cmd(CMD_PIXEL, 5, 64, 0, 0, MODE_ALL, 10'd0);
		send_cmd(CMD_PIXEL, -256, -256, 255, 255, MODE_ALL, 10'h3FF);
		send_cmd(CMD_READ, 0, 0, 0, 0, MODE_CLEAR, 10'd0);
		send_cmd(CMD_READ, 0, 0, 0, 0, MODE_CLEAR, 10'd1023);
		send_cmd(CMD_LINE, 5, 5, 5, 5, MODE_ONE, 10'd0);
		send_cmd(CMD_LINE, 0, 0, 127, 0, MODE_ONE, 10'd0);
		send_cmd(CMD_LINE, 3, -7, 3, 56, MODE_ONE, 10'd0);
		send_cmd(CMD_LINE, 10, 0, 30, 20, MODE_ONE, 10'd0);
		send_cmd(CMD_LINE, 100, 50, 90, 10, MODE_CLEAR, 10'd0);
		send_cmd(CMD_LINE, 120, 40, 0, 30, MODE_ONE, 10'd0);
		send_cmd(CMD_LINE, 0, 0, 50, 50, MODE_TWO, 10'd0);
		send_cmd(CMD_LINE, 0, 0, 50, 50, MODE_ALL, 10'd0);
		send_cmd(CMD_LINE, -256, -256, 255, 255, MODE_ONE, 10'd0);
		send_cmd(CMD_LINE, 255, -256, -256, 255, MODE_CLEAR, 10'd0);
		send_cmd(CMD_READ, 0, 0, 0, 0, MODE_CLEAR, 10'd112);
		send_cmd(CMD_READ, 0, 0, 0, 0, MODE_CLEAR, 10'd192);
		send_cmd(CMD_CLEAR, 0, 0, 0, 0, MODE_CLEAR, 10'd0);
		send_cmd(CMD_READ, 0, 0, 0, 0, MODE_CLEAR, 10'd112);

		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					voff           = 6'd0;
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					voff           = 6'd63;
					send_idle_pct  = 52;
					recv_stall_pct = 0;
				end
				2: begin
					voff           = 6'($urandom_range(62, 1));
					send_idle_pct  = 0;
					recv_stall_pct = 52;
				end
				default: begin
					voff           = 6'($urandom_range(63));
					send_idle_pct  = 28;
					recv_stall_pct = 28;
				end
			endcase
			write_voffset(voff);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// long result hold-off while commands keep coming
				if (phase == 0 && i == 20)
					hold_requests++;
				send_random();
			end
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
